FILE: src/rie_pkg.sv
// Package for the RISC instruction execute block: field widths, opcodes and
// the control state type. Used by the channel interfaces and the top level.
// No dependencies.
package rie_pkg;

  // Payload field widths.
  localparam int OP_W   = 8;
  localparam int REG_W  = 4;
  localparam int IMM_W  = 20;
  localparam int DATA_W = 32;

  // Instruction memory size; the program counter wraps at this size.
  localparam int IMEM_WORDS = 1024;
  localparam int PC_W       = $clog2(IMEM_WORDS);

  // Register file depth and special registers.
  localparam int NUM_REGS = 16;
  localparam logic [REG_W-1:0] ZERO_REG = 4'd0;
  localparam logic [REG_W-1:0] IMM_REG  = 4'd1;
  localparam logic [REG_W-1:0] LINK_REG = 4'd15;

  // Address reduction: bits folded per cycle and number of cycles.
  localparam int AGU_BITS  = 8;
  localparam int AGU_STEPS = DATA_W / AGU_BITS;
  localparam int AGU_CW    = $clog2(AGU_STEPS);

  // Opcodes.
  localparam logic [OP_W-1:0] OP_ADD  = 8'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 8'd1;
  localparam logic [OP_W-1:0] OP_AND  = 8'd2;
  localparam logic [OP_W-1:0] OP_OR   = 8'd3;
  localparam logic [OP_W-1:0] OP_XOR  = 8'd4;
  localparam logic [OP_W-1:0] OP_MUL  = 8'd5;
  localparam logic [OP_W-1:0] OP_SLL  = 8'd6;
  localparam logic [OP_W-1:0] OP_SRA  = 8'd7;
  localparam logic [OP_W-1:0] OP_SRL  = 8'd8;
  localparam logic [OP_W-1:0] OP_BEQ  = 8'd9;
  localparam logic [OP_W-1:0] OP_BNE  = 8'd10;
  localparam logic [OP_W-1:0] OP_BLT  = 8'd11;
  localparam logic [OP_W-1:0] OP_BGT  = 8'd12;
  localparam logic [OP_W-1:0] OP_BLE  = 8'd13;
  localparam logic [OP_W-1:0] OP_BGE  = 8'd14;
  localparam logic [OP_W-1:0] OP_JAL  = 8'd15;
  localparam logic [OP_W-1:0] OP_LW   = 8'd16;
  localparam logic [OP_W-1:0] OP_SW   = 8'd17;
  localparam logic [OP_W-1:0] OP_HALT = 8'd21;

  // Control states of the execute sequencer.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_AGU,
    ST_MEM,
    ST_LOAD
  } state_t;

endpackage

FILE: src/rie_if.sv
// Request and result channel interfaces of the RISC instruction execute block.
// Depends on rie_pkg for the field widths.

// Decoded instruction channel.
interface rie_in_if;
  import rie_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [REG_W-1:0]         dest_reg;
  logic [REG_W-1:0]         src_a_reg;
  logic [REG_W-1:0]         src_b_reg;
  logic signed [IMM_W-1:0]  immediate;

  modport source (output valid, op, dest_reg, src_a_reg, src_b_reg, immediate,
                  input ready);
  modport sink   (input valid, op, dest_reg, src_a_reg, src_b_reg, immediate,
                  output ready);
endinterface

// Execution result channel.
interface rie_out_if;
  import rie_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [PC_W-1:0]           next_pc;
  logic                      halted;
  logic                      reg_write;
  logic [REG_W-1:0]          reg_index;
  logic signed [DATA_W-1:0]  reg_value;
  logic                      branch_taken;
  logic                      mem_write;

  modport source (output valid, next_pc, halted, reg_write, reg_index, reg_value,
                  branch_taken, mem_write, input ready);
  modport sink   (input valid, next_pc, halted, reg_write, reg_index, reg_value,
                  branch_taken, mem_write, output ready);
endinterface

FILE: src/rie_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; a read of the address being written returns old data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/risc_instruction_execute.sv
// RISC instruction execute block: register file and data memory in
// synchronous RAMs, program counter and halt flag in flops.
// Depends on rie_pkg, rie_if (rie_in_if, rie_out_if) and rie_ram.
//
// Usage:
//   instr carries one decoded instruction per request (opcode, rd, rs, rt,
//   20-bit signed immediate). result returns exactly one result per request:
//   next PC, halt flag, register write, taken branch and memory write.
//   A request is accepted when valid and ready are both high at a clock edge.
// Sequencing:
//   The register file is read at acceptance; the instruction executes in the
//   next cycle, its result registered once the result slot is free. ALU,
//   branch, jump and halt instructions sustain one request per cycle while
//   result.ready stays high. After the execute state a store passes the memory
//   state, a load the memory and load states; if DATA_WORDS is not a power of
//   two, the address is first reduced modulo DATA_WORDS eight bits per cycle.
// Reset:
//   rst is synchronous. Registers, PC and halt flag clear at once; the data
//   memory is then cleared one word per cycle through all DATA_WORDS words,
//   during which instr.ready stays low.
// Stall:
//   The result register holds while result.ready is low; the instruction in
//   execution waits behind it, and a new request is taken as soon as the
//   result slot frees up.
module risc_instruction_execute #(
  parameter int DATA_WORDS = 4096
) (
  input  logic      clk,
  input  logic      rst,
  rie_in_if.sink    instr,
  rie_out_if.source result
);
  import rie_pkg::*;

  localparam int  AW    = $clog2(DATA_WORDS);
  localparam bit  POW2  = (DATA_WORDS & (DATA_WORDS - 1)) == 0;
  localparam logic [AW-1:0] CLR_LAST = AW'(DATA_WORDS - 1);
  localparam logic [AW:0]   MOD_N    = (AW + 1)'(DATA_WORDS);
  localparam int  RAW   = $clog2(NUM_REGS);

  // Sequencer state.
  state_t state;
  state_t state_next;

  // Captured request.
  logic [OP_W-1:0]         s_op;
  logic [REG_W-1:0]        s_rd;
  logic [REG_W-1:0]        s_rs;
  logic [REG_W-1:0]        s_rt;
  logic signed [IMM_W-1:0] s_imm;

  // Architectural flops.
  logic [PC_W-1:0]     pc;
  logic                halt_flag;
  logic [NUM_REGS-1:0] rf_vld;
  logic [AW-1:0]       clr_cnt;

  // Forwarding of the register write made at the accepting edge.
  logic              fwd_vld;
  logic [REG_W-1:0]  fwd_idx;
  logic [DATA_W-1:0] fwd_val;

  // Memory access registers.
  logic [DATA_W-1:0] m_sum;
  logic [AW-1:0]     m_rem;
  logic [AGU_CW-1:0] m_cnt;
  logic [AW-1:0]     m_addr;
  logic [DATA_W-1:0] m_d;
  logic [REG_W-1:0]  m_rd;
  logic [PC_W-1:0]   m_npc;
  logic              m_lw;

  // Result register.
  logic              out_valid;
  logic [PC_W-1:0]   out_npc;
  logic              out_halted;
  logic              out_wr;
  logic [REG_W-1:0]  out_idx;
  logic [DATA_W-1:0] out_val;
  logic              out_taken;
  logic              out_memw;

  // RAM ports.
  logic [REG_W-1:0]  rf_ra;
  logic [REG_W-1:0]  rf_rb;
  logic [REG_W-1:0]  rf_rd;
  logic [DATA_W-1:0] rf_da;
  logic [DATA_W-1:0] rf_db;
  logic [DATA_W-1:0] rf_dd;
  logic              rf_we;
  logic [REG_W-1:0]  rf_waddr;
  logic [DATA_W-1:0] rf_wdata;
  logic              dm_we;
  logic [AW-1:0]     dm_waddr;
  logic [DATA_W-1:0] dm_wdata;
  logic [DATA_W-1:0] dm_rdata;

  // Control.
  logic in_fire;
  logic out_free;
  logic is_mem;
  logic done_exec;
  logic done_sw;
  logic done_lw;
  logic done;
  logic clr_active;
  logic lw_wr;

  // Execute datapath.
  logic [DATA_W-1:0] imm32;
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic [DATA_W-1:0] opd;
  logic [PC_W-1:0]   npc_step;
  logic [DATA_W-1:0] e_val;
  logic [REG_W-1:0]  e_idx;
  logic              e_wr;
  logic              e_taken;
  logic              e_halt;
  logic [PC_W-1:0]   e_npc;
  logic [AW-1:0]     agu_rem;

  // Operand read: register 0 is zero, register 1 is the immediate, a write
  // made at the accepting edge is forwarded, and unwritten registers read zero.
  function automatic logic [DATA_W-1:0] read_op(
    input logic [REG_W-1:0]    idx,
    input logic [DATA_W-1:0]   ram_data,
    input logic [DATA_W-1:0]   imm,
    input logic                fv,
    input logic [REG_W-1:0]    fi,
    input logic [DATA_W-1:0]   fd,
    input logic [NUM_REGS-1:0] vld
  );
    logic [DATA_W-1:0] r;
    if (idx == ZERO_REG) begin
      r = '0;
    end else if (idx == IMM_REG) begin
      r = imm;
    end else if (fv && fi == idx) begin
      r = fd;
    end else if (vld[idx[RAW-1:0]]) begin
      r = ram_data;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // Register file: one copy per read port, all written alike.
  rie_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_ra), .rdata(rf_da)
  );
  rie_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_rb), .rdata(rf_db)
  );
  rie_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_d (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_rd), .rdata(rf_dd)
  );

  // Data memory.
  rie_ram #(.WIDTH(DATA_W), .DEPTH(DATA_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(m_addr), .rdata(dm_rdata)
  );

  // Register read addresses come from the request at acceptance, then hold.
  assign rf_ra = in_fire ? instr.src_a_reg : s_rs;
  assign rf_rb = in_fire ? instr.src_b_reg : s_rt;
  assign rf_rd = in_fire ? instr.dest_reg  : s_rd;

  // Operands and the stepped PC.
  assign imm32 = {{(DATA_W - IMM_W){s_imm[IMM_W-1]}}, s_imm};
  assign opa = read_op(s_rs, rf_da, imm32, fwd_vld, fwd_idx, fwd_val, rf_vld);
  assign opb = read_op(s_rt, rf_db, imm32, fwd_vld, fwd_idx, fwd_val, rf_vld);
  assign opd = read_op(s_rd, rf_dd, imm32, fwd_vld, fwd_idx, fwd_val, rf_vld);
  assign npc_step = (s_rd == IMM_REG || s_rs == IMM_REG || s_rt == IMM_REG) ?
                    pc + PC_W'(2) : pc + PC_W'(1);

  // ALU, branch and control decision for the instruction in execution.
  always_comb begin : exec_blk
    logic [DATA_W-1:0] val;
    logic              wr;
    logic              cond;
    logic              big;
    logic [4:0]        sh;
    val     = '0;
    wr      = 1'b0;
    cond    = 1'b0;
    big     = |opb[DATA_W-1:5];
    sh      = opb[4:0];
    e_idx   = s_rd;
    e_halt  = 1'b0;
    e_npc   = npc_step;
    case (s_op)
      OP_ADD:  begin val = opa + opb; wr = 1'b1; end
      OP_SUB:  begin val = opa - opb; wr = 1'b1; end
      OP_AND:  begin val = opa & opb; wr = 1'b1; end
      OP_OR:   begin val = opa | opb; wr = 1'b1; end
      OP_XOR:  begin val = opa ^ opb; wr = 1'b1; end
      OP_MUL:  begin val = opa * opb; wr = 1'b1; end
      OP_SLL:  begin val = big ? '0 : opa << sh; wr = 1'b1; end
      OP_SRA:  begin
        val = big ? {DATA_W{opa[DATA_W-1]}} : DATA_W'($signed(opa) >>> sh);
        wr  = 1'b1;
      end
      OP_SRL:  begin val = big ? '0 : opa >> sh; wr = 1'b1; end
      OP_BEQ:  cond = (opa == opb);
      OP_BNE:  cond = (opa != opb);
      OP_BLT:  cond = ($signed(opa) < $signed(opb));
      OP_BGT:  cond = ($signed(opb) < $signed(opa));
      OP_BLE:  cond = !($signed(opb) < $signed(opa));
      OP_BGE:  cond = !($signed(opa) < $signed(opb));
      OP_JAL:  begin
        val   = DATA_W'(npc_step);
        wr    = 1'b1;
        e_idx = LINK_REG;
        cond  = 1'b1;
      end
      OP_HALT: begin e_halt = 1'b1; e_npc = pc; end
      default: ;
    endcase
    e_taken = cond && (s_op inside {[OP_BEQ:OP_JAL]});
    if (e_taken) begin
      e_npc = opd[PC_W-1:0];
    end
    e_wr = wr && (e_idx > IMM_REG);
    // After a halt nothing changes.
    if (halt_flag) begin
      e_wr    = 1'b0;
      e_taken = 1'b0;
      e_halt  = 1'b0;
      e_npc   = pc;
    end
    e_val = e_wr ? val : '0;
    if (!e_wr) begin
      e_idx = ZERO_REG;
    end
  end

  // One address reduction step: fold the next eight bits into the remainder.
  always_comb begin : agu_blk
    logic [AW:0]   t;
    logic [AW-1:0] r;
    r = m_rem;
    for (int i = 0; i < AGU_BITS; i++) begin
      t = {r, m_sum[DATA_W-1-i]};
      if (t >= MOD_N) begin
        t = t - MOD_N;
      end
      r = t[AW-1:0];
    end
    agu_rem = r;
  end

  // Sequencer control outputs.
  always_comb begin
    clr_active  = (state == ST_CLEAR);
    out_free    = !out_valid || result.ready;
    is_mem      = !halt_flag && (s_op == OP_LW || s_op == OP_SW);
    done_exec   = (state == ST_EXEC) && !is_mem && out_free;
    done_sw     = (state == ST_MEM) && !m_lw && out_free;
    done_lw     = (state == ST_LOAD) && out_free;
    done        = done_exec || done_sw || done_lw;
    instr.ready = (state == ST_IDLE) || done;
    in_fire     = instr.valid && instr.ready;
    lw_wr       = m_rd > IMM_REG;
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE:  if (in_fire) state_next = ST_EXEC;
      ST_EXEC: begin
        if (is_mem) begin
          state_next = POW2 ? ST_MEM : ST_AGU;
        end else if (done_exec) begin
          state_next = in_fire ? ST_EXEC : ST_IDLE;
        end
      end
      ST_AGU:   if (m_cnt == AGU_CW'(AGU_STEPS - 1)) state_next = ST_MEM;
      ST_MEM: begin
        if (m_lw) begin
          state_next = ST_LOAD;
        end else if (done_sw) begin
          state_next = in_fire ? ST_EXEC : ST_IDLE;
        end
      end
      ST_LOAD:  if (done_lw) state_next = in_fire ? ST_EXEC : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Register file write: from execution, or from a returning load.
  assign rf_we    = (done_exec && e_wr) || (done_lw && lw_wr);
  assign rf_waddr = done_lw ? m_rd : e_idx;
  assign rf_wdata = done_lw ? dm_rdata : e_val;

  // Data memory write: clearing pass, or a store.
  assign dm_we    = clr_active || done_sw;
  assign dm_waddr = clr_active ? clr_cnt : m_addr;
  assign dm_wdata = clr_active ? '0 : m_d;

  // Request capture and forwarding of the write made at the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_vld <= 1'b0;
    end else if (in_fire) begin
      fwd_vld <= rf_we;
    end
    if (in_fire) begin
      s_op    <= instr.op;
      s_rd    <= instr.dest_reg;
      s_rs    <= instr.src_a_reg;
      s_rt    <= instr.src_b_reg;
      s_imm   <= instr.immediate;
      fwd_idx <= rf_waddr;
      fwd_val <= rf_wdata;
    end
  end

  // Architectural state: PC, halt flag, register valid bits, clear counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      halt_flag <= 1'b0;
      rf_vld    <= '0;
      clr_cnt   <= '0;
    end else begin
      if (clr_active) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (done_exec) begin
        pc        <= e_npc;
        halt_flag <= halt_flag || e_halt;
      end else if (done_sw || done_lw) begin
        pc <= m_npc;
      end
      if (rf_we) begin
        rf_vld[rf_waddr[RAW-1:0]] <= 1'b1;
      end
    end
  end

  // Memory access path: capture the operands, then reduce the address.
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && is_mem) begin
      m_sum  <= opa + opb;
      m_rem  <= '0;
      m_cnt  <= '0;
      m_d    <= opd;
      m_rd   <= s_rd;
      m_npc  <= npc_step;
      m_lw   <= (s_op == OP_LW);
      if (POW2) begin
        m_addr <= AW'(opa + opb);
      end
    end else if (state == ST_AGU) begin
      m_sum <= m_sum << AGU_BITS;
      m_rem <= agu_rem;
      m_cnt <= m_cnt + AGU_CW'(1);
      if (m_cnt == AGU_CW'(AGU_STEPS - 1)) begin
        m_addr <= agu_rem;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (done_exec) begin
      out_npc    <= e_npc;
      out_halted <= halt_flag || e_halt;
      out_wr     <= e_wr;
      out_idx    <= e_idx;
      out_val    <= e_val;
      out_taken  <= e_taken;
      out_memw   <= 1'b0;
    end else if (done_sw || done_lw) begin
      out_npc    <= m_npc;
      out_halted <= 1'b0;
      out_wr     <= done_lw && lw_wr;
      out_idx    <= (done_lw && lw_wr) ? m_rd : ZERO_REG;
      out_val    <= (done_lw && lw_wr) ? dm_rdata : '0;
      out_taken  <= 1'b0;
      out_memw   <= done_sw;
    end
  end

  assign result.valid        = out_valid;
  assign result.next_pc      = out_npc;
  assign result.halted       = out_halted;
  assign result.reg_write    = out_wr;
  assign result.reg_index    = out_idx;
  assign result.reg_value    = out_val;
  assign result.branch_taken = out_taken;
  assign result.mem_write    = out_memw;

  // No request is taken while the data memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !instr.ready)
    else $error("request accepted during memory clear");

  // Registers zero and one are never written.
  a_no_low_reg_write: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> rf_waddr > IMM_REG)
    else $error("write to register zero or one");

  // An accepted request always executes in the next cycle.
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_EXEC)
    else $error("accepted request not in execution");

  // Outside the clearing pass, data memory is written only by a store.
  a_store_only: assert property (@(posedge clk) disable iff (rst)
    (dm_we && !clr_active) |-> (state == ST_MEM && !m_lw))
    else $error("unexpected data memory write");

  // The halt flag, once set, stays set.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> halt_flag)
    else $error("halt flag cleared");

endmodule
